// ===== sv/isc_pkg.sv =====
package isc_pkg;

   localparam int STACK_DEPTH_DEFAULT = 64;
   localparam int VALUE_WIDTH_DEFAULT = 32;

   localparam logic [2:0] CMD_PUSH = 3'd0;
   localparam logic [2:0] CMD_POP  = 3'd1;
   localparam logic [2:0] CMD_ADD  = 3'd2;
   localparam logic [2:0] CMD_SUB  = 3'd3;
   localparam logic [2:0] CMD_MUL  = 3'd4;
   localparam logic [2:0] CMD_DIV  = 3'd5;

   localparam logic [2:0] STATUS_OK       = 3'd0;
   localparam logic [2:0] STATUS_INVALID  = 3'd1;
   localparam logic [2:0] STATUS_EMPTY    = 3'd2;
   localparam logic [2:0] STATUS_TOO_FEW  = 3'd3;
   localparam logic [2:0] STATUS_DIV_ZERO = 3'd4;
   localparam logic [2:0] STATUS_FULL     = 3'd5;
   localparam logic [2:0] STATUS_HALTED   = 3'd6;

   typedef struct packed {
      logic [2:0]         command;
      logic signed [31:0] push_value;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [31:0] top_value;
      logic [6:0]         depth;
   } rsp_type;

endpackage

// ===== sv/integer_stack_calculator.sv =====
// Integer stack calculator.
// Each request beat carries one command (push, pop, add, sub, mul, div) and a
// push value; each command returns exactly one response beat with a status
// code, the new top of stack (zero when empty) and the new depth.
// Binary operations take the entry below the top as the left operand and the
// top as the right operand. Any error sets a sticky halt; afterwards every
// command reports halted and the stack stays frozen.
// Commands run one at a time under a small microcode program. A command that
// fails or meets the halt goes straight from the idle step to the emit step.
// The shift-add multiply and restoring-divide loops retire one operand bit
// per cycle.
// The request side is ready only while the sequencer sits in its idle step;
// it takes the next request while the previous response still waits in the
// output register. If the receiver stalls, the sequencer holds in its
// emit step until that register frees up.
// Reset empties the stack, clears the halt and drops any pending response.
// The stack storage itself is not cleared.
module integer_stack_calculator
   import isc_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int SPW = $clog2(STACK_DEPTH + 1);
   localparam int CW  = $clog2(VALUE_WIDTH);
   localparam logic [SPW-1:0] SP_FULL = SPW'(STACK_DEPTH);
   localparam logic [SPW-1:0] SP_TWO  = SPW'(2);
   localparam logic [CW-1:0]  CNT_LAST = CW'(VALUE_WIDTH - 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_PUSH, ST_POP_READ, ST_POP_LOAD, ST_BIN_READ, ST_BIN_LOAD,
      ST_ADD, ST_SUB, ST_MUL_SETUP, ST_MUL_LOOP, ST_DIV_SETUP, ST_DIV_LOOP,
      ST_DIV_FIX, ST_WRITE, ST_EMIT
   } step_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_LATCH, OP_PUSH, OP_POP, OP_LOAD_A, OP_ADD, OP_SUB,
      OP_MUL_SETUP, OP_MUL_STEP, OP_DIV_SETUP, OP_DIV_STEP, OP_DIV_FIX,
      OP_WRITE, OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      SEQ_JUMP, SEQ_ACCEPT, SEQ_BRANCH_OP, SEQ_LOOP, SEQ_EMIT
   } seq_type;

   typedef struct packed {
      op_type   op;
      seq_type  seq;
      step_type target;
   } ctrl_type;

   function automatic ctrl_type microcode(input step_type step);
      ctrl_type cw;
      case (step)
         ST_IDLE:      cw = '{OP_LATCH,     SEQ_ACCEPT,    ST_IDLE};
         ST_PUSH:      cw = '{OP_PUSH,      SEQ_JUMP,      ST_EMIT};
         ST_POP_READ:  cw = '{OP_NONE,      SEQ_JUMP,      ST_POP_LOAD};
         ST_POP_LOAD:  cw = '{OP_POP,       SEQ_JUMP,      ST_EMIT};
         ST_BIN_READ:  cw = '{OP_NONE,      SEQ_JUMP,      ST_BIN_LOAD};
         ST_BIN_LOAD:  cw = '{OP_LOAD_A,    SEQ_BRANCH_OP, ST_ADD};
         ST_ADD:       cw = '{OP_ADD,       SEQ_JUMP,      ST_WRITE};
         ST_SUB:       cw = '{OP_SUB,       SEQ_JUMP,      ST_WRITE};
         ST_MUL_SETUP: cw = '{OP_MUL_SETUP, SEQ_JUMP,      ST_MUL_LOOP};
         ST_MUL_LOOP:  cw = '{OP_MUL_STEP,  SEQ_LOOP,      ST_WRITE};
         ST_DIV_SETUP: cw = '{OP_DIV_SETUP, SEQ_JUMP,      ST_DIV_LOOP};
         ST_DIV_LOOP:  cw = '{OP_DIV_STEP,  SEQ_LOOP,      ST_DIV_FIX};
         ST_DIV_FIX:   cw = '{OP_DIV_FIX,   SEQ_JUMP,      ST_WRITE};
         ST_WRITE:     cw = '{OP_WRITE,     SEQ_JUMP,      ST_EMIT};
         ST_EMIT:      cw = '{OP_EMIT,      SEQ_EMIT,      ST_IDLE};
         default:      cw = '{OP_NONE,      SEQ_JUMP,      ST_IDLE};
      endcase
      return cw;
   endfunction

   function automatic logic [VALUE_WIDTH-1:0] magnitude(input logic [VALUE_WIDTH-1:0] v);
      return v[VALUE_WIDTH-1] ? (~v + 1'b1) : v;
   endfunction

   step_type               step_ff, step_in;
   logic [SPW-1:0]         sp_ff, sp_in;
   logic                   halted_ff, halted_in;
   logic [2:0]             cmd_ff, cmd_in;
   logic [2:0]             status_ff, status_in;
   logic signed [31:0]     pv_ff, pv_in;
   logic [VALUE_WIDTH-1:0] tos_ff, tos_in;
   logic [VALUE_WIDTH-1:0] a_ff, a_in;
   logic [VALUE_WIDTH-1:0] x_ff, x_in;
   logic [VALUE_WIDTH-1:0] y_ff, y_in;
   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic                   neg_ff, neg_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic [VALUE_WIDTH-1:0] stack_mem_ff [STACK_DEPTH];
   logic [VALUE_WIDTH-1:0] rd_data_ff;
   logic [AW-1:0]          rd_addr;
   logic                   mem_we;
   logic [AW-1:0]          mem_waddr;
   logic [VALUE_WIDTH-1:0] mem_wdata;

   ctrl_type               cw;
   logic                   req_fire;
   logic                   rsp_free;
   logic [2:0]             status_now;
   logic [SPW-1:0]         sp_minus_two;
   logic [VALUE_WIDTH:0]   trial;
   logic [VALUE_WIDTH:0]   diff;
   logic                   ge;

   assign cw           = microcode(step_ff);
   assign req_ready    = (cw.seq == SEQ_ACCEPT);
   assign req_fire     = req_valid && req_ready;
   assign rsp_free     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff;
   assign sp_minus_two = sp_ff - SP_TWO;
   assign rd_addr      = sp_minus_two[AW-1:0];

   assign trial = {acc_ff, x_ff[VALUE_WIDTH-1]};
   assign diff  = trial - {1'b0, y_ff};
   assign ge    = (trial >= {1'b0, y_ff});

   always_comb begin
      if (halted_ff) begin
         status_now = STATUS_HALTED;
      end else if (req_data.command == CMD_PUSH) begin
         status_now = (sp_ff >= SP_FULL) ? STATUS_FULL : STATUS_OK;
      end else if (req_data.command == CMD_POP) begin
         status_now = (sp_ff == '0) ? STATUS_EMPTY : STATUS_OK;
      end else if (req_data.command inside {[CMD_ADD:CMD_DIV]}) begin
         if (sp_ff < SP_TWO) begin
            status_now = STATUS_TOO_FEW;
         end else if (req_data.command == CMD_DIV && tos_ff == '0) begin
            status_now = STATUS_DIV_ZERO;
         end else begin
            status_now = STATUS_OK;
         end
      end else begin
         status_now = STATUS_INVALID;
      end
   end

   always_comb begin
      step_in      = step_ff;
      sp_in        = sp_ff;
      halted_in    = halted_ff;
      cmd_in       = cmd_ff;
      status_in    = status_ff;
      pv_in        = pv_ff;
      tos_in       = tos_ff;
      a_in         = a_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      acc_in       = acc_ff;
      neg_in       = neg_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_waddr    = sp_ff[AW-1:0];
      mem_wdata    = VALUE_WIDTH'(pv_ff);

      case (cw.op)
         OP_LATCH: begin
            if (req_fire) begin
               cmd_in    = req_data.command;
               pv_in     = req_data.push_value;
               status_in = status_now;
               if (status_now != STATUS_OK) begin
                  halted_in = 1'b1;
               end
            end
         end
         OP_PUSH: begin
            mem_we = 1'b1;
            tos_in = VALUE_WIDTH'(pv_ff);
            sp_in  = sp_ff + 1'b1;
         end
         OP_POP: begin
            tos_in = rd_data_ff;
            sp_in  = sp_ff - 1'b1;
         end
         OP_LOAD_A: begin
            a_in = rd_data_ff;
         end
         OP_ADD: begin
            acc_in = a_ff + tos_ff;
         end
         OP_SUB: begin
            acc_in = a_ff - tos_ff;
         end
         OP_MUL_SETUP: begin
            x_in   = a_ff;
            y_in   = tos_ff;
            acc_in = '0;
            cnt_in = '0;
         end
         OP_MUL_STEP: begin
            acc_in = acc_ff + (y_ff[0] ? x_ff : '0);
            x_in   = {x_ff[VALUE_WIDTH-2:0], 1'b0};
            y_in   = {1'b0, y_ff[VALUE_WIDTH-1:1]};
            cnt_in = cnt_ff + 1'b1;
         end
         OP_DIV_SETUP: begin
            x_in   = magnitude(a_ff);
            y_in   = magnitude(tos_ff);
            neg_in = a_ff[VALUE_WIDTH-1] ^ tos_ff[VALUE_WIDTH-1];
            acc_in = '0;
            cnt_in = '0;
         end
         OP_DIV_STEP: begin
            acc_in = ge ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
            x_in   = {x_ff[VALUE_WIDTH-2:0], ge};
            cnt_in = cnt_ff + 1'b1;
         end
         OP_DIV_FIX: begin
            acc_in = neg_ff ? (~x_ff + 1'b1) : x_ff;
         end
         OP_WRITE: begin
            mem_we    = 1'b1;
            mem_waddr = rd_addr;
            mem_wdata = acc_ff;
            tos_in    = acc_ff;
            sp_in     = sp_ff - 1'b1;
         end
         OP_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in     = 1'b1;
               rsp_in.status    = status_ff;
               rsp_in.top_value = (sp_ff == '0) ? '0 : 32'(tos_ff);
               rsp_in.depth     = 7'(sp_ff);
            end
         end
         default: begin
         end
      endcase

      case (cw.seq)
         SEQ_ACCEPT: begin
            if (req_fire) begin
               if (status_now != STATUS_OK) begin
                  step_in = ST_EMIT;
               end else if (req_data.command == CMD_PUSH) begin
                  step_in = ST_PUSH;
               end else if (req_data.command == CMD_POP) begin
                  step_in = ST_POP_READ;
               end else begin
                  step_in = ST_BIN_READ;
               end
            end
         end
         SEQ_BRANCH_OP: begin
            case (cmd_ff)
               CMD_ADD: step_in = ST_ADD;
               CMD_SUB: step_in = ST_SUB;
               CMD_MUL: step_in = ST_MUL_SETUP;
               default: step_in = ST_DIV_SETUP;
            endcase
         end
         SEQ_LOOP: begin
            step_in = (cnt_ff == CNT_LAST) ? cw.target : step_ff;
         end
         SEQ_EMIT: begin
            step_in = rsp_free ? cw.target : step_ff;
         end
         default: begin
            step_in = cw.target;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= ST_IDLE;
         sp_ff        <= '0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         sp_ff        <= sp_in;
         halted_ff    <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff    <= cmd_in;
      status_ff <= status_in;
      pv_ff     <= pv_in;
      tos_ff    <= tos_in;
      a_ff      <= a_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      acc_ff    <= acc_in;
      neg_ff    <= neg_in;
      cnt_ff    <= cnt_in;
      rsp_ff    <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem_ff[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= stack_mem_ff[rd_addr];
   end

endmodule
